FILE: rtl/csq_pkg.sv
// Counting semaphore with wait queue: shared types, constants and helpers.
// Used by csq_ctrl, csq_dp, the top level and csq_checker. No dependencies.
package csq_pkg;

  localparam int QUEUE_DEPTH    = 64;
  localparam int THREAD_ID_BITS = 8;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;
  localparam int INIT_W   = 15;
  localparam int TID_W    = 8;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QID_W  = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(32767);

  typedef enum logic [MODE_W-1:0] {
    MODE_WAIT      = 3'd0,
    MODE_SIGNAL    = 3'd1,
    MODE_TRY_WAIT  = 3'd2,
    MODE_CLOSE     = 3'd3,
    MODE_BROADCAST = 3'd4,
    MODE_OPEN      = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BLOCKED     = 3'd1,
    ST_WOULD_BLOCK = 3'd2,
    ST_CLOSED      = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_POP
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic out_free;
    logic exec_more;
    logic pop_more;
  } dp_stat_t;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: rtl/csq_ctrl.sv
// Sequencer for the counting semaphore: accepts an operation, executes it,
// then issues one pop per remaining waiter on a drain. Uses csq_pkg.
module csq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  csq_pkg::dp_stat_t stat,
  output csq_pkg::cmd_t     cmd
);
  import csq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd        = CMD_EXEC;
          state_next = stat.exec_more ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd        = CMD_POP;
          state_next = stat.pop_more ? S_DRAIN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/csq_dp.sv
// Semaphore datapath: count, open flag, wait queue memory and pointers,
// and the output word register. Driven by csq_ctrl commands. Uses csq_pkg.
module csq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  csq_pkg::cmd_t                  cmd,
  output csq_pkg::dp_stat_t              stat,
  input  logic                           cfg_we,
  input  logic [csq_pkg::INIT_W-1:0]     cfg_wdata,
  input  logic [csq_pkg::MODE_W-1:0]     mode,
  input  logic [csq_pkg::TID_W-1:0]      thread_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csq_pkg::STATUS_W-1:0]   status,
  output logic signed [csq_pkg::COUNT_W-1:0] count_value,
  output logic                           released_valid,
  output logic [csq_pkg::TID_W-1:0]      released_thread,
  output logic                           last
);
  import csq_pkg::*;

  logic [QID_W-1:0]   mem [QUEUE_DEPTH];
  logic [QID_W-1:0]   rd_data;

  logic [MODE_W-1:0]  mode_r;
  logic [QID_W-1:0]   tid_r;
  logic [INIT_W-1:0]  init_cnt;
  logic [COUNT_W-1:0] count, count_next, count_inc;
  logic               sem_open, sem_open_next;
  logic [QPTR_W-1:0]  head, head_next, tail;
  logic [QLEN_W-1:0]  len;

  logic               push, pop, rel, last_o, load_out;
  status_t            st;
  logic               cnt_le0, inc_le0, q_full, q_empty, len_gt1, drain_op;

  assign count_inc = count + COUNT_W'(1);
  assign cnt_le0   = count[COUNT_W-1] || (count == '0);
  assign inc_le0   = count_inc[COUNT_W-1] || (count_inc == '0);
  assign q_full    = (len == QLEN_W'(QUEUE_DEPTH));
  assign q_empty   = (len == '0);
  assign len_gt1   = (len > QLEN_W'(1));
  assign drain_op  = (mode_r == MODE_CLOSE) || ((mode_r == MODE_BROADCAST) && sem_open);

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.exec_more = drain_op && len_gt1;
  assign stat.pop_more  = len_gt1;

  always_comb begin
    count_next    = count;
    sem_open_next = sem_open;
    push          = 1'b0;
    pop           = 1'b0;
    rel           = 1'b0;
    last_o        = 1'b1;
    st            = ST_OK;
    if (cmd == CMD_EXEC) begin
      if (!sem_open && (mode_r <= MODE_TRY_WAIT || mode_r == MODE_BROADCAST)) begin
        st = ST_CLOSED;
      end else begin
        case (mode_t'(mode_r))
          MODE_WAIT: begin
            if (cnt_le0 && q_full) begin
              st = ST_FULL;
            end else begin
              count_next = count - COUNT_W'(1);
              if (cnt_le0) begin
                push = 1'b1;
                st   = ST_BLOCKED;
              end
            end
          end
          MODE_SIGNAL: begin
            if (count == COUNT_MAX) begin
              st = ST_FULL;
            end else begin
              count_next = count_inc;
              if (inc_le0 && !q_empty) begin
                pop = 1'b1;
                rel = 1'b1;
              end
            end
          end
          MODE_TRY_WAIT: begin
            if (cnt_le0) begin
              st = ST_WOULD_BLOCK;
            end else begin
              count_next = count - COUNT_W'(1);
            end
          end
          MODE_CLOSE: begin
            count_next    = '0;
            sem_open_next = 1'b0;
            if (!q_empty) begin
              pop    = 1'b1;
              rel    = 1'b1;
              last_o = !len_gt1;
            end
          end
          MODE_BROADCAST: begin
            if (!q_empty) begin
              pop    = 1'b1;
              rel    = 1'b1;
              last_o = !len_gt1;
              if (count != COUNT_MAX) begin
                count_next = count_inc;
              end
            end
          end
          MODE_OPEN: begin
            if (!sem_open) begin
              count_next    = COUNT_W'(init_cnt);
              sem_open_next = 1'b1;
            end
          end
          default: st = ST_OK;
        endcase
      end
    end else if (cmd == CMD_POP) begin
      pop    = 1'b1;
      rel    = 1'b1;
      last_o = !len_gt1;
      if (mode_r == MODE_BROADCAST && count != COUNT_MAX) begin
        count_next = count_inc;
      end
    end
  end

  assign load_out  = (cmd == CMD_EXEC) || (cmd == CMD_POP);
  assign head_next = pop ? ptr_inc(head) : head;

  // read ahead at the next head so a pop is followed by valid data
  always_ff @(posedge clk) begin
    rd_data <= mem[head_next];
    if (push) begin
      mem[tail] <= tid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt  <= '0;
      count     <= '0;
      sem_open  <= 1'b1;
      head      <= '0;
      tail      <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_cnt <= cfg_wdata;
      end
      count    <= count_next;
      sem_open <= sem_open_next;
      head     <= head_next;
      if (push) begin
        tail <= ptr_inc(tail);
        len  <= len + QLEN_W'(1);
      end else if (pop) begin
        len  <= len - QLEN_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      mode_r <= mode;
      tid_r  <= thread_id[QID_W-1:0];
    end
    if (load_out) begin
      status          <= st;
      count_value     <= count_next;
      released_valid  <= rel;
      released_thread <= rel ? TID_W'(rd_data) : '0;
      last            <= last_o;
    end
  end

endmodule

FILE: rtl/counting_semaphore_with_wait_queue_top.sv
// Counting semaphore with a FIFO of blocked thread ids. An operation is
// accepted, then executed, before its word is in the output register;
// close and broadcast with n waiters then give n words, one per cycle while
// the output channel does not stall, as the wait queue memory is popped one
// entry a cycle. The next operation is accepted once the last word of the
// current one is in the output register. The initial count written on
// cfg_wdata is loaded into the count only when a closed semaphore is opened.
module counting_semaphore_with_wait_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [csq_pkg::INIT_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [csq_pkg::MODE_W-1:0]         mode,
  input  logic [csq_pkg::TID_W-1:0]          thread_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [csq_pkg::STATUS_W-1:0]       status,
  output logic signed [csq_pkg::COUNT_W-1:0] count_value,
  output logic                               released_valid,
  output logic [csq_pkg::TID_W-1:0]          released_thread,
  output logic                               last
);
  import csq_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  csq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  csq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mode            (mode),
    .thread_id       (thread_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .count_value     (count_value),
    .released_valid  (released_valid),
    .released_thread (released_thread),
    .last            (last)
  );

endmodule

FILE: rtl/csq_checker.sv
// Port-level assertions for the counting semaphore top level, and the bind
// that attaches them. Uses csq_pkg.
module csq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [csq_pkg::STATUS_W-1:0]       status,
  input logic signed [csq_pkg::COUNT_W-1:0] count_value,
  input logic                               released_valid,
  input logic [csq_pkg::TID_W-1:0]          released_thread,
  input logic                               last
);
  import csq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count_value)
      && $stable(released_valid) && $stable(released_thread) && $stable(last))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second operation accepted before execution");

  a_no_release_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !released_valid |-> released_thread == '0)
    else $error("thread id shown without a release");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && !released_valid)
    else $error("non-ok word is not a single final word");

  a_blocked_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BLOCKED |-> count_value[COUNT_W-1])
    else $error("blocked caller with non-negative count");

endmodule

bind counting_semaphore_with_wait_queue_top csq_checker u_csq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .count_value     (count_value),
  .released_valid  (released_valid),
  .released_thread (released_thread),
  .last            (last)
);

FILE: verif/counting_semaphore_with_wait_queue_top_test.sv
// Self-checking testbench for counting_semaphore_with_wait_queue_top: a scoreboard
// class predicts every result word from the accepted operations and the loaded initial count.
// Depends on rtl/csq_pkg.sv and the top-level RTL only.
`timescale 1ns / 100ps

module counting_semaphore_with_wait_queue_top_test;
  import csq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;
  localparam int MAX_GAP    = 13;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                rel_valid;
    logic [TID_W-1:0]    rel_thread;
    logic                last;
  } sem_word_t;

  class sem_scoreboard;
    int unsigned   load_value;
    int            level;
    bit            is_open;
    logic [TID_W-1:0] waiters[$];
    sem_word_t     expected_words[$];
    int            errors;

    function new();
      load_value = 0;
      level      = 0;
      is_open    = 1'b1;
      errors     = 0;
    endfunction

    function void set_initial(int unsigned v);
      load_value = v;
    endfunction

    function void push_word(status_t st, bit rv, logic [TID_W-1:0] rt, bit lst);
      sem_word_t w;
      w.status     = st;
      w.count      = level[COUNT_W-1:0];
      w.rel_valid  = rv;
      w.rel_thread = rv ? rt : '0;
      w.last       = lst;
      expected_words.push_back(w);
    endfunction

    // release every waiter, one word each, or give one word with no release if none wait
    function void release_all(bit count_up);
      logic [TID_W-1:0] id;
      if (waiters.size() == 0) begin
        push_word(ST_OK, 1'b0, '0, 1'b1);
        return;
      end
      while (waiters.size() > 0) begin
        id = waiters.pop_front();
        if (count_up && level < int'(COUNT_MAX))
          level++;
        push_word(ST_OK, 1'b1, id, waiters.size() == 0);
      end
    endfunction

    function void note_op(logic [MODE_W-1:0] m, logic [TID_W-1:0] tid);
      logic [TID_W-1:0] id;
      id = tid & TID_W'((1 << THREAD_ID_BITS) - 1);
      if (!is_open && (m == MODE_WAIT || m == MODE_SIGNAL || m == MODE_TRY_WAIT ||
                       m == MODE_BROADCAST)) begin
        push_word(ST_CLOSED, 1'b0, '0, 1'b1);
        return;
      end
      case (m)
        MODE_WAIT: begin
          if (level <= 0) begin
            if (waiters.size() >= QUEUE_DEPTH) begin
              push_word(ST_FULL, 1'b0, '0, 1'b1);
            end else begin
              level--;
              waiters.push_back(id);
              push_word(ST_BLOCKED, 1'b0, '0, 1'b1);
            end
          end else begin
            level--;
            push_word(ST_OK, 1'b0, '0, 1'b1);
          end
        end
        MODE_SIGNAL: begin
          if (level >= int'(COUNT_MAX)) begin
            push_word(ST_FULL, 1'b0, '0, 1'b1);
          end else begin
            level++;
            if (level <= 0 && waiters.size() > 0)
              push_word(ST_OK, 1'b1, waiters.pop_front(), 1'b1);
            else
              push_word(ST_OK, 1'b0, '0, 1'b1);
          end
        end
        MODE_TRY_WAIT: begin
          if (level > 0) begin
            level--;
            push_word(ST_OK, 1'b0, '0, 1'b1);
          end else begin
            push_word(ST_WOULD_BLOCK, 1'b0, '0, 1'b1);
          end
        end
        MODE_CLOSE: begin
          level   = 0;
          is_open = 1'b0;
          release_all(1'b0);
        end
        MODE_BROADCAST: release_all(1'b1);
        MODE_OPEN: begin
          if (!is_open) begin
            level   = int'(load_value);
            is_open = 1'b1;
          end
          push_word(ST_OK, 1'b0, '0, 1'b1);
        end
        default: push_word(ST_OK, 1'b0, '0, 1'b1);
      endcase
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_word(sem_word_t got);
      sem_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual status %0d count %0d",
                 $time, got.status, $signed(got.count));
        return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status)
        mismatch("status", want.status, got.status);
      if (got.count !== want.count)
        mismatch("count_value", int'($signed(want.count)), int'($signed(got.count)));
      if (got.rel_valid !== want.rel_valid)
        mismatch("released_valid", want.rel_valid, got.rel_valid);
      if (got.rel_thread !== want.rel_thread)
        mismatch("released_thread", want.rel_thread, got.rel_thread);
      if (got.last !== want.last)
        mismatch("last", want.last, got.last);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [INIT_W-1:0]          cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic [MODE_W-1:0]          mode;
  logic [TID_W-1:0]           thread_id;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        status;
  logic signed [COUNT_W-1:0]  count_value;
  logic                       released_valid;
  logic [TID_W-1:0]           released_thread;
  logic                       last;

  sem_scoreboard sb = new();
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  counting_semaphore_with_wait_queue_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .thread_id       (thread_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .count_value     (count_value),
    .released_valid  (released_valid),
    .released_thread (released_thread),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TID_W-1:0] tid);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    thread_id <= tid;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_op(m, tid);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_initial(input logic [INIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_initial(v);
  endtask

  function automatic logic [TID_W-1:0] any_tid();
    return TID_W'($urandom_range(0, (1 << TID_W) - 1));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_WAIT;
    if (r < 55) return MODE_SIGNAL;
    if (r < 65) return MODE_TRY_WAIT;
    if (r < 71) return MODE_CLOSE;
    if (r < 77) return MODE_BROADCAST;
    if (r < 95) return MODE_OPEN;
    if (r < 97) return MODE_RSVD_6;
    return MODE_RSVD_7;
  endfunction

  // output side: check each accepted word, then stall for a random while
  initial begin
    int g;
    sem_word_t w;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        w.status     = status;
        w.count      = count_value;
        w.rel_valid  = released_valid;
        w.rel_thread = released_thread;
        w.last       = last;
        sb.check_word(w);
        g = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("counting_semaphore_with_wait_queue_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    mode      <= MODE_WAIT;
    thread_id <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every mode, field extremes, closed and overflow cases
    load_initial(INIT_W'(32767));
    send_word(MODE_TRY_WAIT, 8'h00);
    send_word(MODE_WAIT, 8'hFF);
    send_word(MODE_WAIT, 8'h00);
    send_word(MODE_SIGNAL, 8'h3C);
    send_word(MODE_BROADCAST, 8'hC3);
    send_word(MODE_BROADCAST, 8'h00);
    send_word(MODE_SIGNAL, 8'hFF);
    send_word(MODE_TRY_WAIT, 8'h01);
    send_word(MODE_WAIT, 8'hA5);
    send_word(MODE_WAIT, 8'h5A);
    send_word(MODE_CLOSE, 8'h80);
    send_word(MODE_CLOSE, 8'h7F);
    send_word(MODE_WAIT, 8'h11);
    send_word(MODE_SIGNAL, 8'h22);
    send_word(MODE_TRY_WAIT, 8'h33);
    send_word(MODE_BROADCAST, 8'h44);
    send_word(MODE_RSVD_6, 8'h55);
    send_word(MODE_RSVD_7, 8'hAA);
    send_word(MODE_OPEN, 8'h00);
    send_word(MODE_OPEN, 8'hFF);
    send_word(MODE_SIGNAL, 8'h01);
    send_word(MODE_WAIT, 8'h02);
    send_word(MODE_SIGNAL, 8'h04);
    send_word(MODE_RSVD_7, 8'h08);
    settle();

    // fill the wait queue to its depth and past it, then drain
    load_initial('0);
    send_word(MODE_CLOSE, any_tid());
    send_word(MODE_OPEN, any_tid());
    repeat (QUEUE_DEPTH + 3) send_word(MODE_WAIT, any_tid());
    repeat ($urandom_range(1, 6)) send_word(MODE_SIGNAL, any_tid());
    send_word(MODE_TRY_WAIT, any_tid());
    send_word($urandom_range(0, 1) ? MODE_CLOSE : MODE_BROADCAST, any_tid());
    send_word(MODE_OPEN, any_tid());
    settle();

    // random phases under different initial counts
    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 2);
      case (p)
        0: load_initial(INIT_W'($urandom_range(1, 3)));
        1: load_initial(INIT_W'(32767));
        2: load_initial(INIT_W'($urandom_range(0, 32767)));
        default: load_initial(INIT_W'($urandom_range(0, 2)));
      endcase
      send_word(MODE_CLOSE, any_tid());
      send_word(MODE_OPEN, any_tid());
      repeat (6) send_word(pick_mode(), any_tid());
      settle();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("counting_semaphore_with_wait_queue_top regression: pass");
    end else begin
      $display("counting_semaphore_with_wait_queue_top regression: fail");
    end
    $finish;
  end

endmodule
